// File: sv/pps_pkg.sv
package pps_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;

	localparam int PID_W  = 16;
	localparam int TIME_W = 32;
	localparam int PRIO_W = 8;
	localparam int END_W  = 33;
	localparam int LVL_W  = 5;

	localparam logic MODE_ARRIVE   = 1'b0;
	localparam logic MODE_COMPLETE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT
	} state_t;

	typedef struct packed {
		logic [PID_W-1:0]  pid;
		logic [TIME_W-1:0] arrival;
		logic [PRIO_W-1:0] prio;
		logic [TIME_W-1:0] remaining;
	} entry_t;

	typedef struct packed {
		entry_t            e;
		logic [TIME_W-1:0] start_time;
		logic [END_W-1:0]  end_time;
	} run_t;

	function automatic run_t make_run(entry_t e, logic [TIME_W-1:0] t);
		run_t r;
		r.e          = e;
		r.start_time = t;
		r.end_time   = {1'b0, t} + {1'b0, e.remaining};
		return r;
	endfunction

endpackage

// File: sv/preemptive_priority_scheduler_top.sv
// Preemptive priority scheduler.
// Command port: an item (one scheduling event) is taken on a clock edge where
// start is high and busy is low. mode selects arrival or completion of the
// running process. Each item gives exactly one result: the running process
// record, the ready queue level and the overflow flag, shown for one cycle
// with done high. The receiver cannot stall; a result is never held.
// An arrival: done rises on the cycle after acceptance, and
// busy stays low, so items may follow back to back.
// A completion with an empty queue also keeps busy low. Otherwise the ready
// queue memory (one read and one write port, registered read) is scanned
// once for the most urgent entry, one entry per cycle, then the entries
// behind it are moved down one slot per cycle. busy is high during that
// sequence.
// Reset clears the running record (idle CPU) and the queue level; queue
// memory contents need no clearing.
module preemptive_priority_scheduler_top
	import pps_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              mode,
	input  logic [TIME_W-1:0] now_time,
	input  logic [PID_W-1:0]  new_pid,
	input  logic [TIME_W-1:0] new_arrival,
	input  logic [PRIO_W-1:0] new_priority,
	input  logic [TIME_W-1:0] new_remaining,
	output logic              done,
	output logic [PID_W-1:0]  run_pid,
	output logic [TIME_W-1:0] run_arrival,
	output logic [PRIO_W-1:0] run_priority,
	output logic [TIME_W-1:0] run_remaining,
	output logic [TIME_W-1:0] run_start,
	output logic [END_W-1:0]  run_end,
	output logic [LVL_W-1:0]  queue_level,
	output logic              overflow
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	state_t            state_q, state_d;
	logic [CW-1:0]     count_q, count_d;
	logic [CW-1:0]     ptr_q, ptr_d;
	entry_t            best_q, best_d;
	logic [AW-1:0]     best_idx_q, best_idx_d;
	logic [TIME_W-1:0] now_q, now_d;
	run_t              run_q, run_d;
	logic              done_q, done_d;
	logic              ovf_q, ovf_d;

	entry_t            mem [QUEUE_DEPTH];
	entry_t            rd_data_q;
	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     wr_addr;
	entry_t            wr_data;
	logic              we;

	entry_t            new_e;
	entry_t            cur;
	logic              better;
	logic [TIME_W-1:0] elapsed;
	logic [TIME_W-1:0] rem_cut;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			ptr_q      <= '0;
			best_idx_q <= '0;
			run_q      <= '0;
			done_q     <= 1'b0;
			ovf_q      <= 1'b0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			ptr_q      <= ptr_d;
			best_idx_q <= best_idx_d;
			run_q      <= run_d;
			done_q     <= done_d;
			ovf_q      <= ovf_d;
		end
	end

	always_ff @(posedge clk) begin
		best_q <= best_d;
		now_q  <= now_d;
	end

	always_comb begin
		new_e.pid       = new_pid;
		new_e.arrival   = new_arrival;
		new_e.prio      = new_priority;
		new_e.remaining = new_remaining;

		elapsed = (now_time >= run_q.start_time) ? now_time - run_q.start_time : '0;
		if (run_q.start_time != '0) begin
			rem_cut = (run_q.e.remaining > elapsed) ? run_q.e.remaining - elapsed : '0;
		end else begin
			rem_cut = run_q.e.remaining;
		end

		cur    = rd_data_q;
		better = (ptr_q == '0) || (cur.prio < best_q.prio) ||
			((cur.prio == best_q.prio) && (cur.arrival < best_q.arrival));

		state_d    = state_q;
		count_d    = count_q;
		ptr_d      = ptr_q;
		best_d     = best_q;
		best_idx_d = best_idx_q;
		now_d      = now_q;
		run_d      = run_q;
		done_d     = 1'b0;
		ovf_d      = ovf_q;
		we         = 1'b0;
		wr_addr    = '0;
		wr_data    = new_e;
		rd_addr    = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (mode == MODE_ARRIVE) begin
						done_d = 1'b1;
						ovf_d  = 1'b0;
						priority if (run_q.e.pid == '0) begin
							run_d = make_run(new_e, now_time);
						end else if (count_q == CW'(QUEUE_DEPTH)) begin
							ovf_d = 1'b1;
						end else if (new_priority < run_q.e.prio) begin
							we                = 1'b1;
							wr_addr           = AW'(count_q);
							wr_data           = run_q.e;
							wr_data.remaining = rem_cut;
							count_d           = count_q + CW'(1);
							run_d             = make_run(new_e, now_time);
						end else begin
							we      = 1'b1;
							wr_addr = AW'(count_q);
							wr_data = new_e;
							count_d = count_q + CW'(1);
						end
					end else if (count_q == '0) begin
						done_d = 1'b1;
						ovf_d  = 1'b0;
						run_d  = '0;
					end else begin
						now_d   = now_time;
						ptr_d   = '0;
						rd_addr = '0;
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (better) begin
					best_d     = cur;
					best_idx_d = AW'(ptr_q);
				end
				if (ptr_q == count_q - CW'(1)) begin
					ptr_d   = CW'(best_idx_d) + CW'(1);
					state_d = ST_SHIFT;
				end else begin
					ptr_d = ptr_q + CW'(1);
				end
				rd_addr = AW'(ptr_d);
			end
			ST_SHIFT: begin
				if (ptr_q < count_q) begin
					we      = 1'b1;
					wr_addr = AW'(ptr_q - CW'(1));
					wr_data = rd_data_q;
					ptr_d   = ptr_q + CW'(1);
					rd_addr = AW'(ptr_d);
				end else begin
					count_d = count_q - CW'(1);
					run_d   = make_run(best_q, now_q);
					done_d  = 1'b1;
					ovf_d   = 1'b0;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy          = (state_q != ST_IDLE);
	assign done          = done_q;
	assign run_pid       = run_q.e.pid;
	assign run_arrival   = run_q.e.arrival;
	assign run_priority  = run_q.e.prio;
	assign run_remaining = run_q.e.remaining;
	assign run_start     = run_q.start_time;
	assign run_end       = run_q.end_time;
	assign queue_level   = LVL_W'(count_q);
	assign overflow      = ovf_q;

endmodule
